>>> design/gia_pkg.sv
// ----------------------------------------------------------------------------
// gia_pkg
// Shared types and constants of the Gaussian integer ALU: operation codes,
// the input and result beat layouts and the record carried by the
// divide / square-root pipeline.
// ----------------------------------------------------------------------------
package gia_pkg;

    localparam int W = 32;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_MAG = 3'd4;

    // number of quotient bits resolved, one per iteration stage
    localparam int DIV_STEPS  = 2 * W;
    // number of root bits resolved, one per iteration stage
    localparam int ROOT_STEPS = W;

    typedef struct packed {
        logic [2:0]          func;
        logic signed [W-1:0] a_real;
        logic signed [W-1:0] a_imag;
        logic signed [W-1:0] b_real;
        logic signed [W-1:0] b_imag;
    } in_t;

    typedef struct packed {
        logic signed [W-1:0] result_real;
        logic signed [W-1:0] result_imag;
        logic                zero_divisor;
    } out_t;

    // record carried through the iteration stages
    typedef struct packed {
        logic              valid;
        logic [2:0]        func;
        logic              zero;
        logic [W-1:0]      simple_r;
        logic [W-1:0]      simple_i;
        logic              neg_r;
        logic              neg_i;
        logic [2*W-1:0]    num_r;
        logic [2*W-1:0]    num_i;
        logic [2*W-1:0]    den;
        logic [2*W-1:0]    rem_r;
        logic [2*W-1:0]    rem_i;
        logic [W-1:0]      quo_r;
        logic [W-1:0]      quo_i;
        logic [2*W-1:0]    rad;
        logic [W+1:0]      srem;
        logic [W-1:0]      root;
    } stage_t;

endpackage

>>> design/gia_step.sv
// ----------------------------------------------------------------------------
// gia_step
// One register stage of the iteration pipeline: resolves one quotient bit
// of both the real and imaginary divisions and, when enabled, one bit of
// the integer square root.
// ----------------------------------------------------------------------------
module gia_step #(
    parameter bit ROOT_STEP = 1'b1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  gia_pkg::stage_t cur,
    output gia_pkg::stage_t nxt_reg
);

    localparam int W = gia_pkg::W;

    gia_pkg::stage_t   nxt_next;
    logic [2*W:0]      sh_r;
    logic [2*W:0]      sh_i;
    logic [2*W:0]      den_x;
    logic [W+3:0]      sh_s;
    logic [W+3:0]      trial;

    // one restoring division step per part, one root digit
    always_comb begin
        nxt_next = cur;
        den_x    = {1'b0, cur.den};
        sh_r     = {cur.rem_r, cur.num_r[2*W-1]};
        sh_i     = {cur.rem_i, cur.num_i[2*W-1]};
        sh_s     = {cur.srem, cur.rad[2*W-1:2*W-2]};
        trial    = {2'b00, cur.root, 2'b01};

        nxt_next.num_r = {cur.num_r[2*W-2:0], 1'b0};
        nxt_next.num_i = {cur.num_i[2*W-2:0], 1'b0};

        if (sh_r >= den_x) begin
            nxt_next.rem_r = (2*W)'(sh_r - den_x);
            nxt_next.quo_r = {cur.quo_r[W-2:0], 1'b1};
        end else begin
            nxt_next.rem_r = sh_r[2*W-1:0];
            nxt_next.quo_r = {cur.quo_r[W-2:0], 1'b0};
        end

        if (sh_i >= den_x) begin
            nxt_next.rem_i = (2*W)'(sh_i - den_x);
            nxt_next.quo_i = {cur.quo_i[W-2:0], 1'b1};
        end else begin
            nxt_next.rem_i = sh_i[2*W-1:0];
            nxt_next.quo_i = {cur.quo_i[W-2:0], 1'b0};
        end

        if (ROOT_STEP) begin
            nxt_next.rad = {cur.rad[2*W-3:0], 2'b00};
            if (sh_s >= trial) begin
                nxt_next.srem = (W+2)'(sh_s - trial);
                nxt_next.root = {cur.root[W-2:0], 1'b1};
            end else begin
                nxt_next.srem = sh_s[W+1:0];
                nxt_next.root = {cur.root[W-2:0], 1'b0};
            end
        end
    end

    // advance on enable, valid cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nxt_reg.valid <= 1'b0;
        end else if (en) begin
            nxt_reg <= nxt_next;
        end
    end

endmodule

>>> design/gaussian_integer_alu.sv
// ----------------------------------------------------------------------------
// gaussian_integer_alu
// Pipelined ALU on complex integers: add, subtract, multiply, divide
// (truncating, zero-divisor flag) and floor magnitude of a.
// ----------------------------------------------------------------------------
//  channel | ports                      | beat
//  --------+----------------------------+-----------------------------
//  input   | s_valid s_ready s_data     | func, a_real/imag, b_real/imag
//  result  | m_valid m_ready m_data     | result_real/imag, zero_divisor
//
// One beat accepted per cycle while s_ready is high; the path to m_valid runs
// through input, product, sum and seed registers, 64 one-bit division stages
// and the output register, the first of them loaded at the accepting edge.
// Reset (aresetn low, synchronous) drops every beat in flight.
// A stalled result sits in the output register; one more beat lands in a
// skid register, after which the whole pipeline holds and s_ready falls.
// ----------------------------------------------------------------------------
module gaussian_integer_alu (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gia_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gia_pkg::out_t m_data
);

    localparam int W = gia_pkg::W;
    localparam int N = gia_pkg::DIV_STEPS;

    typedef struct packed {
        logic                  valid;
        logic [2:0]            func;
        logic signed [W-1:0]   sum_r;
        logic signed [W-1:0]   sum_i;
        logic signed [2*W-1:0] prr;
        logic signed [2*W-1:0] pii;
        logic signed [2*W-1:0] pri;
        logic signed [2*W-1:0] pir;
        logic [2*W-1:0]        sq0;
        logic [2*W-1:0]        sq1;
    } prod_t;

    typedef struct packed {
        logic                valid;
        logic [2:0]          func;
        logic [W-1:0]        simple_r;
        logic [W-1:0]        simple_i;
        logic signed [2*W:0] nr;
        logic signed [2*W:0] ni;
        logic [2*W-1:0]      d;
    } sum_t;

    logic            en;
    logic            in_valid_reg;
    gia_pkg::in_t    in_reg;
    prod_t           prod_reg;
    prod_t           prod_next;
    sum_t            sum_reg;
    sum_t            sum_next;
    gia_pkg::stage_t pipe [0:N];
    gia_pkg::stage_t init_next;
    logic signed [W-1:0] x0;
    logic signed [W-1:0] x1;
    gia_pkg::out_t   fin;
    gia_pkg::stage_t last;
    logic            skid_valid_reg;
    gia_pkg::out_t   skid_reg;
    logic            m_valid_reg;
    gia_pkg::out_t   m_data_reg;
    logic            out_free;

    // hold everything while the skid register is occupied
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // capture the input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
            in_reg       <= s_data;
        end
    end

    // products; squares take a for magnitude, b otherwise
    always_comb begin
        x0 = (in_reg.func == gia_pkg::FUNC_MAG) ? in_reg.a_real : in_reg.b_real;
        x1 = (in_reg.func == gia_pkg::FUNC_MAG) ? in_reg.a_imag : in_reg.b_imag;
        prod_next.valid = in_valid_reg;
        prod_next.func  = in_reg.func;
        if (in_reg.func == gia_pkg::FUNC_SUB) begin
            prod_next.sum_r = in_reg.a_real - in_reg.b_real;
            prod_next.sum_i = in_reg.a_imag - in_reg.b_imag;
        end else begin
            prod_next.sum_r = in_reg.a_real + in_reg.b_real;
            prod_next.sum_i = in_reg.a_imag + in_reg.b_imag;
        end
        prod_next.prr = (2*W)'(in_reg.a_real) * (2*W)'(in_reg.b_real);
        prod_next.pii = (2*W)'(in_reg.a_imag) * (2*W)'(in_reg.b_imag);
        prod_next.pri = (2*W)'(in_reg.a_real) * (2*W)'(in_reg.b_imag);
        prod_next.pir = (2*W)'(in_reg.a_imag) * (2*W)'(in_reg.b_real);
        prod_next.sq0 = (2*W)'((2*W)'(x0) * (2*W)'(x0));
        prod_next.sq1 = (2*W)'((2*W)'(x1) * (2*W)'(x1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
        end else if (en) begin
            prod_reg <= prod_next;
        end
    end

    // exact numerators, divisor and wrapped simple results
    always_comb begin
        sum_next.valid = prod_reg.valid;
        sum_next.func  = prod_reg.func;
        if (prod_reg.func == gia_pkg::FUNC_MUL) begin
            sum_next.simple_r = W'(prod_reg.prr - prod_reg.pii);
            sum_next.simple_i = W'(prod_reg.pri + prod_reg.pir);
        end else begin
            sum_next.simple_r = prod_reg.sum_r;
            sum_next.simple_i = prod_reg.sum_i;
        end
        sum_next.nr = (2*W+1)'(prod_reg.prr) + (2*W+1)'(prod_reg.pii);
        sum_next.ni = (2*W+1)'(prod_reg.pir) - (2*W+1)'(prod_reg.pri);
        sum_next.d  = prod_reg.sq0 + prod_reg.sq1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg.valid <= 1'b0;
        end else if (en) begin
            sum_reg <= sum_next;
        end
    end

    // split numerators into sign and magnitude, seed the iterations
    always_comb begin
        init_next          = '0;
        init_next.valid    = sum_reg.valid;
        init_next.func     = sum_reg.func;
        init_next.zero     = (sum_reg.d == '0);
        init_next.simple_r = sum_reg.simple_r;
        init_next.simple_i = sum_reg.simple_i;
        init_next.neg_r    = sum_reg.nr[2*W];
        init_next.neg_i    = sum_reg.ni[2*W];
        init_next.num_r    = sum_reg.nr[2*W] ? (2*W)'(-sum_reg.nr) : sum_reg.nr[2*W-1:0];
        init_next.num_i    = sum_reg.ni[2*W] ? (2*W)'(-sum_reg.ni) : sum_reg.ni[2*W-1:0];
        init_next.den      = sum_reg.d;
        init_next.rad      = sum_reg.d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe[0].valid <= 1'b0;
        end else if (en) begin
            pipe[0] <= init_next;
        end
    end

    // one quotient bit per stage, root bits in the first stages
    for (genvar k = 0; k < N; k++) begin : g_step
        gia_step #(
            .ROOT_STEP (k < gia_pkg::ROOT_STEPS)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .cur     (pipe[k]),
            .nxt_reg (pipe[k+1])
        );
    end

    // select the finished result
    always_comb begin
        last = pipe[N];
        fin  = '0;
        case (last.func)
            gia_pkg::FUNC_ADD, gia_pkg::FUNC_SUB, gia_pkg::FUNC_MUL: begin
                fin.result_real = last.simple_r;
                fin.result_imag = last.simple_i;
            end
            gia_pkg::FUNC_DIV: begin
                if (last.zero) begin
                    fin.zero_divisor = 1'b1;
                end else begin
                    fin.result_real = last.neg_r ? -last.quo_r : last.quo_r;
                    fin.result_imag = last.neg_i ? -last.quo_i : last.quo_i;
                end
            end
            gia_pkg::FUNC_MAG: begin
                fin.result_real = last.root[W-1] ? {1'b0, {(W-1){1'b1}}} : last.root;
            end
            default: begin
                fin = '0;
            end
        endcase
    end

    // output register with one skid entry behind it
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                m_valid_reg    <= 1'b1;
                m_data_reg     <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            m_valid_reg <= last.valid;
            m_data_reg  <= fin;
        end else if (last.valid) begin
            skid_valid_reg <= 1'b1;
            skid_reg       <= fin;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // skid entry is only used behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry occupied with empty output register");

    // a stalled output with a new beat arriving fills the skid entry
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && !skid_valid_reg && pipe[N].valid)
        |=> skid_valid_reg)
        else $error("finished beat not caught by skid entry");

    // a zero divisor forces a zero result
    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.zero_divisor)
        |-> (m_data.result_real == '0 && m_data.result_imag == '0))
        else $error("zero divisor with nonzero result");

endmodule
